// ===== sv/ldcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Lens distortion map package
// Fixed-point formats, register codes and the configuration bundle shared
// by the coordinate map, its register bank, its channels and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ldcm_pkg;

  // Coordinate normalization and output format
  localparam int COORD_BITS    = 12;
  localparam int OUT_FRAC_BITS = 8;
  localparam int FRAC_BITS     = 28;                        // Q.28 intermediates
  localparam int NORM_SHIFT    = 24 - COORD_BITS;           // 4-frac pixels to Q.28
  localparam int XX_SHIFT      = FRAC_BITS - 2 * NORM_SHIFT;
  localparam int DX_SHIFT      = FRAC_BITS - NORM_SHIFT;
  localparam int OUT_SHIFT     = FRAC_BITS - OUT_FRAC_BITS - COORD_BITS;

  // Field widths
  localparam int COL_W      = 12;
  localparam int OUT_W      = 21;
  localparam int CENTER_W   = 16;
  localparam int COEF_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CENTER_W-1:0] CENTER_RESET = 16'h8000;

  // Pipeline depth including the output register
  localparam int NSTG = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_RAD_K1   = 3'd2,
    REG_RAD_K2   = 3'd3,
    REG_RAD_K3   = 3'd4,
    REG_TAN_P1   = 3'd5,
    REG_TAN_P2   = 3'd6,
    REG_TAN_P3   = 3'd7
  } ldcm_reg_idx_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [COEF_W-1:0]   radial_k1;
    logic [COEF_W-1:0]   radial_k2;
    logic [COEF_W-1:0]   radial_k3;
    logic [COEF_W-1:0]   tangential_p1;
    logic [COEF_W-1:0]   tangential_p2;
    logic [COEF_W-1:0]   tangential_p3;
  } ldcm_cfg_t;

endpackage

// ===== sv/ldcm_in_if.sv =====
// ----------------------------------------------------------------------------
// Pixel request channel
// Valid/ready channel carrying one destination pixel column and row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ldcm_in_if import ldcm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] pixel_column;
  logic [COL_W-1:0] pixel_row;

  modport source (output valid, output pixel_column, output pixel_row, input ready);
  modport sink   (input valid, input pixel_column, input pixel_row, output ready);
endinterface

// ===== sv/ldcm_out_if.sv =====
// ----------------------------------------------------------------------------
// Source coordinate channel
// Valid/ready channel carrying one mapped source coordinate pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ldcm_out_if import ldcm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] source_x;
  logic signed [OUT_W-1:0] source_y;

  modport source (output valid, output source_x, output source_y, input ready);
  modport sink   (input valid, input source_x, input source_y, output ready);
endinterface

// ===== sv/ldcm_cfg.sv =====
// ----------------------------------------------------------------------------
// Lens distortion map register bank
// Holds the distortion center and the six model coefficients.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldcm_cfg import ldcm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output ldcm_cfg_t             cfg
);

  ldcm_cfg_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= {CENTER_RESET, CENTER_RESET, {(6 * COEF_W){1'b0}}};
    end else if (cfg_we) begin
      case (ldcm_reg_idx_t'(cfg_index))
        REG_CENTER_X: regs_r.center_x      <= cfg_wdata[CENTER_W-1:0];
        REG_CENTER_Y: regs_r.center_y      <= cfg_wdata[CENTER_W-1:0];
        REG_RAD_K1:   regs_r.radial_k1     <= cfg_wdata[COEF_W-1:0];
        REG_RAD_K2:   regs_r.radial_k2     <= cfg_wdata[COEF_W-1:0];
        REG_RAD_K3:   regs_r.radial_k3     <= cfg_wdata[COEF_W-1:0];
        REG_TAN_P1:   regs_r.tangential_p1 <= cfg_wdata[COEF_W-1:0];
        REG_TAN_P2:   regs_r.tangential_p2 <= cfg_wdata[COEF_W-1:0];
        REG_TAN_P3:   regs_r.tangential_p3 <= cfg_wdata[COEF_W-1:0];
        default:      regs_r               <= regs_r;
      endcase
    end
  end

  assign cfg = regs_r;

endmodule

// ===== sv/lens_distortion_coordinate_map.sv =====
// ----------------------------------------------------------------------------
// Lens distortion coordinate map
// Maps a destination pixel (column, row) to its source coordinate under the
// Brown-Conrady model with three radial and three tangential coefficients.
// Requests arrive on in_chan, results leave on out_chan, both valid/ready;
// a request is taken at a clock edge with valid and ready high.
// Coefficients and the distortion center must be written through the cfg_ port
// only while no request is in flight; the block itself does not enforce this.
// Throughput: one request per cycle until a stalled receiver fills the
// pipeline; fifteen stages, each holding a rank of multipliers, a rounding
// add, a sum, the offset, the output position or the output saturation.
// Each stage carries a valid bit; a stage loads whenever it or any stage
// after it is empty, so bubbles close up and in_chan.ready stays high until
// all fifteen stages hold requests behind a stalled receiver.
// A stall holds the output register and the unbroken run of full stages
// behind it; nothing is lost.
// Reset (rst_n low, synchronous) empties the pipeline and loads the center
// registers with 2048.0 pixels and the coefficients with zero.
// Outputs saturate to the 21-bit signed range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lens_distortion_coordinate_map import ldcm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ldcm_in_if.sink               in_chan,
  ldcm_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Stage numbers
  localparam int ST_DIFF  = 0;
  localparam int ST_SQ    = 1;
  localparam int ST_SQRND = 2;
  localparam int ST_R2    = 3;
  localparam int ST_MUL1  = 4;
  localparam int ST_SUM1  = 5;
  localparam int ST_MUL2  = 6;
  localparam int ST_SUM2  = 7;
  localparam int ST_MUL3  = 8;
  localparam int ST_RAD   = 9;
  localparam int ST_MUL4  = 10;
  localparam int ST_RND4  = 11;
  localparam int ST_DISP  = 12;
  localparam int ST_POS   = 13;
  localparam int ST_OUT   = NSTG - 1;

  // Datapath widths, sized from the value ranges of the normalized terms
  localparam int DXW   = 17;            // centered offset, 4 frac bits
  localparam int PW    = 2 * DXW;       // offset products
  localparam int XW    = 29;            // dx^2, dy^2, dx*dy in Q.28
  localparam int R2W   = 30;
  localparam int SW    = 31;            // r2 + 2 dx^2
  localparam int K3R2W = COEF_W + R2W;
  localparam int P1SW  = COEF_W + SW;
  localparam int P2XW  = COEF_W + XW;
  localparam int A1W   = 34;
  localparam int SCW   = 34;
  localparam int Q1W   = 35;
  localparam int Q2W   = 33;
  localparam int TW    = 35;
  localparam int M1W   = A1W + R2W;
  localparam int A2W   = 36;
  localparam int M2W   = A2W + R2W;
  localparam int RADW  = 37;
  localparam int MDW   = DXW + RADW;
  localparam int SPLIT = 17;            // scale is split for the tangential product
  localparam int PTLW  = TW + SPLIT + 1;
  localparam int PTHW  = TW + SCW - SPLIT;
  localparam int PTW   = 68;
  localparam int QDW   = 38;
  localparam int DSW   = 41;
  localparam int VW    = 34;
  localparam int RW    = 72;            // rounding helper width

  localparam logic signed [RW-1:0] ONE_RW    = RW'(1);
  localparam logic signed [VW-1:0] OUT_MAX_V = (VW'(1) <<< (OUT_W - 1)) - VW'(1);
  localparam logic signed [VW-1:0] OUT_MIN_V = -(VW'(1) <<< (OUT_W - 1));

  // (p / 2^sh) rounded half away from zero, plus k
  function automatic logic signed [RW-1:0] rnd_shift(input logic signed [RW-1:0] p,
                                                     input logic signed [RW-1:0] k,
                                                     input int unsigned sh);
    logic signed [RW-1:0] t;
    t = p + (k <<< sh) + (ONE_RW <<< (sh - 1));
    if (p[RW-1]) t = t - ONE_RW;
    return t >>> sh;
  endfunction

  // Pixel center plus displacement, displacement rounded half up
  function automatic logic signed [RW-1:0] out_pos(input logic [COL_W-1:0] idx,
                                                   input logic signed [DSW-1:0] disp);
    logic signed [RW-1:0] base;
    base = (RW'(signed'({1'b0, idx})) <<< OUT_FRAC_BITS) + (ONE_RW <<< (OUT_FRAC_BITS - 1));
    return (RW'(disp) + (base <<< OUT_SHIFT) + (ONE_RW <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [VW-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > OUT_MAX_V) r = OUT_MAX_V[OUT_W-1:0];
    else if (v < OUT_MIN_V) r = OUT_MIN_V[OUT_W-1:0];
    else r = v[OUT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  ldcm_cfg_t cfg;

  ldcm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  logic signed [COEF_W-1:0] k1, k2, k3, p1, p2, p3;

  assign k1 = signed'(cfg.radial_k1);
  assign k2 = signed'(cfg.radial_k2);
  assign k3 = signed'(cfg.radial_k3);
  assign p1 = signed'(cfg.tangential_p1);
  assign p2 = signed'(cfg.tangential_p2);
  assign p3 = signed'(cfg.tangential_p3);

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] en;
  logic [NSTG-1:0] vld_shift;

  // A stage loads when it or any later stage is empty, or the result leaves
  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      en[k] = out_chan.ready || (((~vld_r) >> k) != '0);
    end
  end

  assign vld_shift = {vld_r[NSTG-2:0], in_chan.valid};

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_shift[k] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_chan.ready  = en[ST_DIFF];
  assign out_chan.valid = vld_r[ST_OUT];

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic        [COL_W-1:0] col_r [ST_DIFF:ST_DISP];
  logic        [COL_W-1:0] row_r [ST_DIFF:ST_DISP];
  logic signed [DXW-1:0]   dx_r  [ST_DIFF:ST_RAD];
  logic signed [DXW-1:0]   dy_r  [ST_DIFF:ST_RAD];
  logic signed [PW-1:0]    pxx_r, pyy_r, pxy_r;
  logic signed [XW-1:0]    xx_r, yy_r;
  logic signed [XW-1:0]    xy_r  [ST_SQRND:ST_R2];
  logic signed [R2W-1:0]   r2_r  [ST_R2:ST_SUM2];
  logic signed [SW-1:0]    sx_r, sy_r;
  logic signed [K3R2W-1:0] k3r2_r, p3r2_r;
  logic signed [P1SW-1:0]  p1sx_r, p2sy_r;
  logic signed [P2XW-1:0]  p2xy_r, p1xy_r;
  logic signed [A1W-1:0]   a1_r;
  logic signed [SCW-1:0]   scale_r [ST_SUM1:ST_RAD];
  logic signed [Q1W-1:0]   q_p1sx_r, q_p2sy_r;
  logic signed [Q2W-1:0]   q_p2xy_r, q_p1xy_r;
  logic signed [TW-1:0]    tx_r [ST_MUL2:ST_RAD];
  logic signed [TW-1:0]    ty_r [ST_MUL2:ST_RAD];
  logic signed [M1W-1:0]   m1_r;
  logic signed [A2W-1:0]   a2_r;
  logic signed [M2W-1:0]   m2_r;
  logic signed [RADW-1:0]  rad_r;
  logic signed [MDW-1:0]   mdx_r, mdy_r;
  logic signed [PTLW-1:0]  ptlx_r, ptly_r;
  logic signed [PTHW-1:0]  pthx_r, pthy_r;
  logic signed [QDW-1:0]   qdx_r, qdy_r;
  logic signed [PTW-1:0]   ptx_r, pty_r;
  logic signed [DSW-1:0]   dispx_r, dispy_r;
  logic signed [VW-1:0]    vx_r, vy_r;
  logic signed [OUT_W-1:0] srcx_r, srcy_r;

  always_ff @(posedge clk) begin
    // Offset of the pixel center from the distortion center
    if (en[ST_DIFF]) begin
      col_r[ST_DIFF] <= in_chan.pixel_column;
      row_r[ST_DIFF] <= in_chan.pixel_row;
      dx_r[ST_DIFF]  <= {1'b0, in_chan.pixel_column, 4'b1000} - {1'b0, cfg.center_x};
      dy_r[ST_DIFF]  <= {1'b0, in_chan.pixel_row, 4'b1000} - {1'b0, cfg.center_y};
    end

    for (int k = ST_SQ; k <= ST_DISP; k++) begin
      if (en[k]) begin
        col_r[k] <= col_r[k-1];
        row_r[k] <= row_r[k-1];
      end
    end
    for (int k = ST_SQ; k <= ST_RAD; k++) begin
      if (en[k]) begin
        dx_r[k] <= dx_r[k-1];
        dy_r[k] <= dy_r[k-1];
      end
    end

    if (en[ST_SQ]) begin
      pxx_r <= PW'(dx_r[ST_DIFF]) * PW'(dx_r[ST_DIFF]);
      pyy_r <= PW'(dy_r[ST_DIFF]) * PW'(dy_r[ST_DIFF]);
      pxy_r <= PW'(dx_r[ST_DIFF]) * PW'(dy_r[ST_DIFF]);
    end

    if (en[ST_SQRND]) begin
      xx_r            <= XW'(rnd_shift(RW'(pxx_r), '0, XX_SHIFT));
      yy_r            <= XW'(rnd_shift(RW'(pyy_r), '0, XX_SHIFT));
      xy_r[ST_SQRND]  <= XW'(rnd_shift(RW'(pxy_r), '0, XX_SHIFT));
    end

    if (en[ST_R2]) begin
      r2_r[ST_R2] <= R2W'(xx_r) + R2W'(yy_r);
      sx_r        <= (SW'(xx_r) <<< 1) + SW'(xx_r) + SW'(yy_r);
      sy_r        <= (SW'(yy_r) <<< 1) + SW'(yy_r) + SW'(xx_r);
      xy_r[ST_R2] <= xy_r[ST_SQRND];
    end

    for (int k = ST_MUL1; k <= ST_SUM2; k++) begin
      if (en[k]) r2_r[k] <= r2_r[k-1];
    end

    if (en[ST_MUL1]) begin
      k3r2_r <= K3R2W'(k3) * K3R2W'(r2_r[ST_R2]);
      p3r2_r <= K3R2W'(p3) * K3R2W'(r2_r[ST_R2]);
      p1sx_r <= P1SW'(p1) * P1SW'(sx_r);
      p2sy_r <= P1SW'(p2) * P1SW'(sy_r);
      p2xy_r <= P2XW'(p2) * P2XW'(xy_r[ST_R2]);
      p1xy_r <= P2XW'(p1) * P2XW'(xy_r[ST_R2]);
    end

    if (en[ST_SUM1]) begin
      a1_r             <= A1W'(rnd_shift(RW'(k3r2_r), RW'(k2), FRAC_BITS));
      scale_r[ST_SUM1] <= SCW'(rnd_shift(RW'(p3r2_r), ONE_RW <<< FRAC_BITS, FRAC_BITS));
      q_p1sx_r         <= Q1W'(rnd_shift(RW'(p1sx_r), '0, FRAC_BITS));
      q_p2sy_r         <= Q1W'(rnd_shift(RW'(p2sy_r), '0, FRAC_BITS));
      q_p2xy_r         <= Q2W'(rnd_shift(RW'(p2xy_r), '0, FRAC_BITS));
      q_p1xy_r         <= Q2W'(rnd_shift(RW'(p1xy_r), '0, FRAC_BITS));
    end

    for (int k = ST_MUL2; k <= ST_RAD; k++) begin
      if (en[k]) scale_r[k] <= scale_r[k-1];
    end

    if (en[ST_MUL2]) begin
      m1_r          <= M1W'(a1_r) * M1W'(r2_r[ST_SUM1]);
      tx_r[ST_MUL2] <= TW'(q_p1sx_r) + (TW'(q_p2xy_r) <<< 1);
      ty_r[ST_MUL2] <= (TW'(q_p1xy_r) <<< 1) + TW'(q_p2sy_r);
    end

    for (int k = ST_SUM2; k <= ST_RAD; k++) begin
      if (en[k]) begin
        tx_r[k] <= tx_r[k-1];
        ty_r[k] <= ty_r[k-1];
      end
    end

    if (en[ST_SUM2]) a2_r <= A2W'(rnd_shift(RW'(m1_r), RW'(k1), FRAC_BITS));
    if (en[ST_MUL3]) m2_r <= M2W'(a2_r) * M2W'(r2_r[ST_SUM2]);
    if (en[ST_RAD])  rad_r <= RADW'(rnd_shift(RW'(m2_r), '0, FRAC_BITS));

    // Radial terms and the tangential term times scale, as two partial products
    if (en[ST_MUL4]) begin
      mdx_r  <= MDW'(dx_r[ST_RAD]) * MDW'(rad_r);
      mdy_r  <= MDW'(dy_r[ST_RAD]) * MDW'(rad_r);
      ptlx_r <= PTLW'(tx_r[ST_RAD]) * PTLW'(signed'({1'b0, scale_r[ST_RAD][SPLIT-1:0]}));
      ptly_r <= PTLW'(ty_r[ST_RAD]) * PTLW'(signed'({1'b0, scale_r[ST_RAD][SPLIT-1:0]}));
      pthx_r <= PTHW'(tx_r[ST_RAD]) * PTHW'(signed'(scale_r[ST_RAD][SCW-1:SPLIT]));
      pthy_r <= PTHW'(ty_r[ST_RAD]) * PTHW'(signed'(scale_r[ST_RAD][SCW-1:SPLIT]));
    end

    if (en[ST_RND4]) begin
      qdx_r <= QDW'(rnd_shift(RW'(mdx_r), '0, DX_SHIFT));
      qdy_r <= QDW'(rnd_shift(RW'(mdy_r), '0, DX_SHIFT));
      ptx_r <= (PTW'(pthx_r) <<< SPLIT) + PTW'(ptlx_r);
      pty_r <= (PTW'(pthy_r) <<< SPLIT) + PTW'(ptly_r);
    end

    if (en[ST_DISP]) begin
      dispx_r <= DSW'(rnd_shift(RW'(ptx_r), RW'(qdx_r), FRAC_BITS));
      dispy_r <= DSW'(rnd_shift(RW'(pty_r), RW'(qdy_r), FRAC_BITS));
    end

    if (en[ST_POS]) begin
      vx_r <= VW'(out_pos(col_r[ST_DISP], dispx_r));
      vy_r <= VW'(out_pos(row_r[ST_DISP], dispy_r));
    end

    if (en[ST_OUT]) begin
      srcx_r <= sat_out(vx_r);
      srcy_r <= sat_out(vy_r);
    end
  end

  assign out_chan.source_x = srcx_r;
  assign out_chan.source_y = srcy_r;

endmodule

// ===== sv/ldcm_checker.sv =====
// ----------------------------------------------------------------------------
// Lens distortion map checker
// Watches the channel ports of the coordinate map: result hold under stall,
// request bookkeeping and back pressure only when the pipeline is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ldcm_checker import ldcm_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [OUT_W-1:0] source_x,
  input logic signed [OUT_W-1:0] source_y
);

  localparam int CNT_W = $clog2(NSTG + 1);

  logic             in_acc;
  logic             out_acc;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign cnt_nxt = cnt_r + CNT_W'(in_acc) - CNT_W'(out_acc);

  // Requests inside the block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(source_x) && $stable(source_y))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result shown with no request in flight");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> cnt_r == CNT_W'(NSTG))
    else $error("request refused while the pipeline has room");

endmodule

bind lens_distortion_coordinate_map ldcm_checker u_ldcm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .source_x  (out_chan.source_x),
  .source_y  (out_chan.source_y)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lens distortion coordinate map testbench
// Sends destination pixels through the request channel under a series of
// center and coefficient settings. A scoreboard computes the expected source
// coordinate of each accepted request in its own Q.28 arithmetic and checks
// the results in order. Both channel sides idle and stall at random, and one
// long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------

module tb;
  import ldcm_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int DRAIN_CYCLES  = NSTG + 5;
  localparam int QUIET_LIMIT   = 1000;
  localparam int HOLD_CYCLES   = 80;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_ITEMS   = 57;

  localparam longint SAT_Q   = longint'(1) << 62;
  localparam longint ONE_Q   = longint'(1) << FRAC_BITS;
  localparam longint OUT_MAX = (longint'(1) << (OUT_W - 1)) - 1;
  localparam longint OUT_MIN = -(longint'(1) << (OUT_W - 1));

  typedef struct packed {
    logic [COL_W-1:0]        col;
    logic [COL_W-1:0]        row;
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } src_coord_t;

  class coord_scoreboard;
    logic [CENTER_W-1:0]      center_x, center_y;
    logic signed [COEF_W-1:0] k1, k2, k3, p1, p2, p3;
    src_coord_t               expected_q[$];
    int                       mismatches;
    int                       checked;

    function new();
      center_x   = CENTER_RESET;
      center_y   = CENTER_RESET;
      k1 = '0; k2 = '0; k3 = '0;
      p1 = '0; p2 = '0; p3 = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(ldcm_reg_idx_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_CENTER_X: center_x = d[CENTER_W-1:0];
        REG_CENTER_Y: center_y = d[CENTER_W-1:0];
        REG_RAD_K1:   k1 = d[COEF_W-1:0];
        REG_RAD_K2:   k2 = d[COEF_W-1:0];
        REG_RAD_K3:   k3 = d[COEF_W-1:0];
        REG_TAN_P1:   p1 = d[COEF_W-1:0];
        REG_TAN_P2:   p2 = d[COEF_W-1:0];
        REG_TAN_P3:   p3 = d[COEF_W-1:0];
        default:      ;
      endcase
    endfunction

    function longint clamp_q(longint v);
      if (v > SAT_Q) return SAT_Q;
      if (v < -SAT_Q) return -SAT_Q;
      return v;
    endfunction

    function longint add_q(longint a, longint b);
      return clamp_q(clamp_q(a) + clamp_q(b));
    endfunction

    // Q.28 product: magnitude rounded half away from zero, then saturated
    function longint mul_q(longint a, longint b);
      logic [127:0] ma, mb, prod;
      longint       sa, sb, q;
      sa   = clamp_q(a);
      sb   = clamp_q(b);
      ma   = (sa < 0) ? 128'(-sa) : 128'(sa);
      mb   = (sb < 0) ? 128'(-sb) : 128'(sb);
      prod = ma * mb;
      prod = (prod + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      q    = (prod > 128'(SAT_Q)) ? SAT_Q : longint'(prod[63:0]);
      return ((sa < 0) != (sb < 0)) ? -q : q;
    endfunction

    // Round half toward +infinity into output fractional pixels
    function longint shift_round(longint v);
      longint w;
      w = clamp_q(v) + (longint'(1) << (OUT_SHIFT - 1));
      return w >>> OUT_SHIFT;
    endfunction

    function logic signed [OUT_W-1:0] to_source(logic [COL_W-1:0] idx, longint disp);
      longint v;
      v = (longint'(idx) << OUT_FRAC_BITS) + (longint'(1) << (OUT_FRAC_BITS - 1))
          + shift_round(disp);
      if (v > OUT_MAX) v = OUT_MAX;
      if (v < OUT_MIN) v = OUT_MIN;
      return v[OUT_W-1:0];
    endfunction

    function void note_pixel(logic [COL_W-1:0] col, logic [COL_W-1:0] row);
      longint     dxn, dyn, xx, yy, xy, r2, rad, scale, tx, ty, disp_x, disp_y;
      src_coord_t e;
      // pixel center in 4-fractional-bit pixels minus the distortion center
      dxn    = ((longint'(col) << 4) + 8 - longint'(center_x)) * (longint'(1) << NORM_SHIFT);
      dyn    = ((longint'(row) << 4) + 8 - longint'(center_y)) * (longint'(1) << NORM_SHIFT);
      xx     = mul_q(dxn, dxn);
      yy     = mul_q(dyn, dyn);
      xy     = mul_q(dxn, dyn);
      r2     = add_q(xx, yy);
      rad    = mul_q(add_q(mul_q(add_q(mul_q(k3, r2), k2), r2), k1), r2);
      scale  = add_q(ONE_Q, mul_q(p3, r2));
      tx     = add_q(mul_q(p1, add_q(r2, add_q(xx, xx))),
                     add_q(mul_q(p2, xy), mul_q(p2, xy)));
      ty     = add_q(add_q(mul_q(p1, xy), mul_q(p1, xy)),
                     mul_q(p2, add_q(r2, add_q(yy, yy))));
      disp_x = add_q(mul_q(dxn, rad), mul_q(tx, scale));
      disp_y = add_q(mul_q(dyn, rad), mul_q(ty, scale));
      e.col  = col;
      e.row  = row;
      e.x    = to_source(col, disp_x);
      e.y    = to_source(row, disp_y);
      expected_q = {expected_q, e};
    endfunction

    task log_mismatch(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      mismatches++;
    endtask

    task check_coord(logic signed [OUT_W-1:0] x, logic signed [OUT_W-1:0] y);
      src_coord_t e;
      if (expected_q.size() == 0) begin
        log_mismatch($sformatf("result x=%0d y=%0d with no request pending", x, y));
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (x !== e.x)
        log_mismatch($sformatf("pixel (%0d,%0d) source_x got %0d expected %0d",
                               e.col, e.row, x, e.x));
      if (y !== e.y)
        log_mismatch($sformatf("pixel (%0d,%0d) source_y got %0d expected %0d",
                               e.col, e.row, y, e.y));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic [CFG_DATA_W-1:0] cfg_plan [0:2**CFG_IDX_W-1];

  coord_scoreboard sb;
  int              tx_gap_max;
  int              rx_stall_max;
  bit              rx_hold_req;
  int              settings_count;

  ldcm_in_if  in_if ();
  ldcm_out_if out_if ();

  lens_distortion_coordinate_map DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  task send_pixel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row);
    int gap;
    gap = $urandom_range(tx_gap_max, 0);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.pixel_column <= col;
    in_if.pixel_row    <= row;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_pixel(col, row);
  endtask

  task load_config();
    ldcm_reg_idx_t idx;
    idx = idx.first();
    do begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= cfg_plan[idx];
      sb.set_reg(idx, cfg_plan[idx]);
      @(posedge clk);
      idx = idx.next();
    end while (idx != idx.first());
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // Drop valid, wait for every pending result, then let the pipeline settle
  task drain();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_coef();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return {{8{r[24]}}, r[23:0]};
      2:       return {{5{r[27]}}, r[26:0]};
      3:       return r;
      default: return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  // Upper bits stay random: only the low 16 belong to the center
  function automatic logic [CFG_DATA_W-1:0] pick_center();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(3, 0))
      0:       return {r[31:16], 16'h0000};
      1:       return {r[31:16], 16'hFFFF};
      default: return r;
    endcase
  endfunction

  function automatic logic [COL_W-1:0] pick_pixel();
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return '1;
      default: return COL_W'($urandom_range(2**COL_W - 1, 0));
    endcase
  endfunction

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int stall;
    bit hold_done;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (rx_hold_req && !hold_done) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        stall = $urandom_range(rx_stall_max, 0);
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid && out_if.ready)
      sb.check_coord(out_if.source_x, out_if.source_y);
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no request moved for %0d cycles", QUIET_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    sb             = new();
    settings_count = 0;
    tx_gap_max     = 18;
    rx_stall_max   = 18;
    rx_hold_req    = 1'b0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_CENTER_X;
    cfg_wdata          <= '0;
    in_if.valid        <= 1'b0;
    in_if.pixel_column <= '0;
    in_if.pixel_row    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: plain half-pixel offset at the corners, near the center and at alternating-bit pixels
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd2047, 12'd2048);
    send_pixel(12'd2048, 12'd2047);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    drain();

    // Largest coefficients, center at the origin: saturate high
    cfg_plan[REG_CENTER_X]  = 32'hFFFF_0000;
    cfg_plan[REG_CENTER_Y]  = 32'h0000_0000;
    cfg_plan[REG_RAD_K1]    = 32'h7FFF_FFFF;
    cfg_plan[REG_RAD_K2]    = 32'h7FFF_FFFF;
    cfg_plan[REG_RAD_K3]    = 32'h7FFF_FFFF;
    cfg_plan[REG_TAN_P1]    = 32'h7FFF_FFFF;
    cfg_plan[REG_TAN_P2]    = 32'h7FFF_FFFF;
    cfg_plan[REG_TAN_P3]    = 32'h7FFF_FFFF;
    load_config();
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd2048, 12'd100);
    send_pixel(12'd1, 12'd4094);
    drain();

    // Most negative coefficients, center at the far corner: saturate low
    cfg_plan[REG_CENTER_X]  = 32'h0000_FFFF;
    cfg_plan[REG_CENTER_Y]  = 32'hFFFF_FFFF;
    cfg_plan[REG_RAD_K1]    = 32'h8000_0000;
    cfg_plan[REG_RAD_K2]    = 32'h8000_0000;
    cfg_plan[REG_RAD_K3]    = 32'h8000_0000;
    cfg_plan[REG_TAN_P1]    = 32'h8000_0000;
    cfg_plan[REG_TAN_P2]    = 32'h8000_0000;
    cfg_plan[REG_TAN_P3]    = 32'h8000_0000;
    load_config();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4094, 12'd1);
    send_pixel(12'd3000, 12'd0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      cfg_plan[REG_CENTER_X] = pick_center();
      cfg_plan[REG_CENTER_Y] = pick_center();
      cfg_plan[REG_RAD_K1]   = pick_coef();
      cfg_plan[REG_RAD_K2]   = pick_coef();
      cfg_plan[REG_RAD_K3]   = pick_coef();
      cfg_plan[REG_TAN_P1]   = pick_coef();
      cfg_plan[REG_TAN_P2]   = pick_coef();
      cfg_plan[REG_TAN_P3]   = pick_coef();
      load_config();
      tx_gap_max   = (p % 3 == 1) ? 0 : 18;
      rx_stall_max = (p % 4 == 2) ? 0 : 18;
      // Back-to-back requests against a held receiver fill the pipeline
      if (p == 4) begin
        tx_gap_max  = 0;
        rx_hold_req = 1'b1;
      end
      repeat (PHASE_ITEMS) send_pixel(pick_pixel(), pick_pixel());
      drain();
    end

    $display("Checked %0d coordinate pairs under %0d register settings,", sb.checked,
             settings_count + 1);
    $display("including saturating coefficients, extreme centers and a full-pipeline stall.");
    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ldcm_pkg.sv
sv/ldcm_in_if.sv
sv/ldcm_out_if.sv
sv/ldcm_cfg.sv
sv/lens_distortion_coordinate_map.sv
sv/ldcm_checker.sv
sim/tb.sv
